/* rtl/core/stock_locate_symbol_directory_unit_macros.svh */
// Assertion macros for the stock locate symbol directory.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef STOCK_LOCATE_SYMBOL_DIRECTORY_UNIT_MACROS_SVH
`define STOCK_LOCATE_SYMBOL_DIRECTORY_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SLD_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SLD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SLD_ASSERT_RST(lbl, clk, rstn, prop, msg)
`define SLD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/core/sld_pkg.sv */
// Shared types and constants of the stock locate symbol directory.
// No dependencies; used by the controller, the datapath, the top level and the bench.
package sld_pkg;

    localparam int SYMBOL_BYTES = 8;
    localparam int SYMBOL_W     = 8 * SYMBOL_BYTES;
    localparam int LOCATE_W     = 16;
    localparam int QSLOT_W      = 2;
    localparam int STATUS_W     = 2;
    localparam int KNOWN_W      = 17;
    localparam int DISC_W       = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int NUM_SYM_REGS = 4;

    localparam logic [7:0]          SPACE_BYTE = 8'h20;
    localparam logic [7:0]          NUL_BYTE   = 8'h00;
    localparam logic [SYMBOL_W-1:0] SPACE_WORD = {SYMBOL_BYTES{SPACE_BYTE}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REQ_SYMBOL_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_ENABLE  = 3'd4;

    localparam logic OP_OBSERVE = 1'b0;
    localparam logic OP_QUERY   = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_BYTE = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_CONFLICT  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL
    } t_state;

    typedef struct packed {
        logic                op;
        logic [LOCATE_W-1:0] locate;
        logic [SYMBOL_W-1:0] stock_symbol;
        logic [QSLOT_W-1:0]  query_slot;
    } t_item;

    typedef struct packed {
        t_status             status;
        logic                known;
        logic                selected;
        logic [SYMBOL_W-1:0] symbol_out;
        logic [KNOWN_W-1:0]  known_count;
        logic [DISC_W-1:0]   discovered_count;
        logic                all_discovered;
        logic                slot_found;
        logic [LOCATE_W-1:0] slot_locate;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic clear_we;   // write one cleared directory entry
        logic in_ready;   // input side open, read address from input
        logic commit;     // evaluate the held item, write back, load result
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last; // clearing pass at last entry
        logic in_valid;
        logic out_free;   // result register empty or being drained
    } t_dp_status;

endpackage

/* rtl/core/sld_stream_if.sv */
// Valid/ready stream channel carrying one payload of type T.
// Depends on nothing; payload types come from sld_pkg at instantiation.
interface sld_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/sld_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/sld_ctrl.sv */
// Controller of the directory: clearing pass, accept, evaluate/write-back.
// Depends on sld_pkg and the assertion macros header.
`include "stock_locate_symbol_directory_unit_macros.svh"
module sld_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sld_pkg::t_dp_status i_st,
    output sld_pkg::t_ctrl_cmd  o_cmd
);
    import sld_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_st.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_st.in_valid) n_state = S_EVAL;
            end
            S_EVAL: begin
                if (i_st.out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_CLEAR: o_cmd.clear_we = 1'b1;
            S_IDLE:  o_cmd.in_ready = 1'b1;
            S_EVAL:  o_cmd.commit   = i_st.out_free;
            default: o_cmd = '0;
        endcase
    end

    `SLD_ASSERT_RST(a_accept_to_eval, i_clk, i_rst_n, i_st.in_valid && o_cmd.in_ready |=> r_state == S_EVAL, "accepted transfer did not move to evaluation")
    `SLD_ASSERT_RST(a_eval_holds, i_clk, i_rst_n, (r_state == S_EVAL) && !i_st.out_free |=> r_state == S_EVAL, "item dropped while result register full")
endmodule

/* rtl/core/sld_datapath.sv */
// Datapath of the directory: config registers, locate memory, slot discovery
// state, counters and the result register. Depends on sld_pkg, sld_ram,
// sld_stream_if and the assertion macros header.
`include "stock_locate_symbol_directory_unit_macros.svh"
module sld_datapath #(
    parameter int LOCATE_BITS = 16,
    parameter int REQ_SLOTS   = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sld_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sld_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    sld_stream_if.sink                         i_item,
    sld_stream_if.source                       o_result,
    input  sld_pkg::t_ctrl_cmd                 i_cmd,
    output sld_pkg::t_dp_status                o_st
);
    import sld_pkg::*;

    localparam int DEPTH   = 1 << LOCATE_BITS;
    localparam int ENTRY_W = SYMBOL_W + 2;

    // configuration
    logic [SYMBOL_W-1:0]    r_req_symbol [REQ_SLOTS];
    logic [REQ_SLOTS-1:0]   r_slot_en;

    // held item
    logic                   r_op;
    logic [LOCATE_BITS-1:0] r_loc;
    logic [SYMBOL_W-1:0]    r_sym;
    logic [QSLOT_W-1:0]     r_qs;

    // discovery state and counters
    logic [REQ_SLOTS-1:0]   r_slot_disc, n_slot_disc;
    logic [LOCATE_BITS-1:0] r_slot_loc [REQ_SLOTS];
    logic [KNOWN_W-1:0]     r_known_cnt, n_known_cnt;
    logic [DISC_W-1:0]      r_disc_cnt, n_disc_cnt;
    logic [LOCATE_BITS-1:0] r_clr_addr;

    logic                   r_out_valid;
    t_result                r_out, n_out;

    // memory ports
    logic                   mem_we;
    logic [LOCATE_BITS-1:0] mem_waddr, mem_raddr;
    logic [ENTRY_W-1:0]     mem_wdata, mem_rdata;

    logic                   accept;
    logic                   rd_valid, rd_sel;
    logic [SYMBOL_W-1:0]    rd_sym;
    logic                   has_nul, is_space, is_obs, store_new, sel;
    logic [REQ_SLOTS-1:0]   match, new_disc;
    logic [DISC_W-1:0]      new_cnt, en_cnt;
    t_status                status;
    logic                   q_found;
    logic [LOCATE_BITS-1:0] q_loc;

    assign accept        = i_item.valid && i_cmd.in_ready;
    assign i_item.ready  = i_cmd.in_ready;
    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

    assign o_st.clear_last = &r_clr_addr;
    assign o_st.in_valid   = i_item.valid;
    assign o_st.out_free   = !r_out_valid || o_result.ready;

    // entry layout: {valid, selected, symbol}
    assign rd_valid = mem_rdata[ENTRY_W-1];
    assign rd_sel   = mem_rdata[ENTRY_W-2];
    assign rd_sym   = mem_rdata[SYMBOL_W-1:0];

    assign mem_raddr = i_cmd.in_ready ? i_item.payload.locate[LOCATE_BITS-1:0] : r_loc;
    assign mem_we    = i_cmd.clear_we || (i_cmd.commit && store_new);
    assign mem_waddr = i_cmd.clear_we ? r_clr_addr : r_loc;
    assign mem_wdata = i_cmd.clear_we ? '0 : {1'b1, sel, r_sym};

    sld_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_dir_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // symbol checks and slot matching
    always_comb begin
        has_nul = 1'b0;
        for (int b = 0; b < SYMBOL_BYTES; b++) begin
            if (r_sym[8*b +: 8] == NUL_BYTE) has_nul = 1'b1;
        end
        is_space = (r_sym == SPACE_WORD);
        is_obs   = (r_op == OP_OBSERVE);
        for (int s = 0; s < REQ_SLOTS; s++) begin
            match[s] = r_slot_en[s] && (r_req_symbol[s] == r_sym);
        end
        sel       = |match;
        store_new = is_obs && !has_nul && !is_space && !rd_valid;
        new_disc  = store_new ? (match & ~r_slot_disc) : '0;

        status = ST_OK;
        if (is_obs) begin
            priority if (has_nul) status = ST_ZERO_BYTE;
            else if (is_space) status = ST_EMPTY;
            else if (rd_valid && (rd_sym != r_sym)) status = ST_CONFLICT;
            else status = ST_OK;
        end
    end

    // next counters and discovery
    always_comb begin
        new_cnt = '0;
        en_cnt  = '0;
        for (int s = 0; s < REQ_SLOTS; s++) begin
            new_cnt = new_cnt + DISC_W'(new_disc[s]);
            en_cnt  = en_cnt + DISC_W'(r_slot_en[s]);
        end
        n_slot_disc = r_slot_disc | new_disc;
        n_disc_cnt  = r_disc_cnt + new_cnt;
        n_known_cnt = r_known_cnt + KNOWN_W'(store_new);
    end

    // queried slot, after this item's update
    always_comb begin
        q_found = 1'b0;
        q_loc   = '0;
        for (int s = 0; s < REQ_SLOTS; s++) begin
            if (int'(r_qs) == s && n_slot_disc[s]) begin
                q_found = 1'b1;
                q_loc   = new_disc[s] ? r_loc : r_slot_loc[s];
            end
        end
    end

    always_comb begin
        n_out                  = '0;
        n_out.status           = status;
        n_out.known            = store_new || rd_valid;
        n_out.selected         = store_new ? sel : (rd_valid && rd_sel);
        n_out.symbol_out       = store_new ? r_sym : (rd_valid ? rd_sym : '0);
        n_out.known_count      = n_known_cnt;
        n_out.discovered_count = n_disc_cnt;
        n_out.all_discovered   = (n_disc_cnt == en_cnt);
        n_out.slot_found       = q_found;
        n_out.slot_locate      = LOCATE_W'(q_loc);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < REQ_SLOTS; s++) r_req_symbol[s] <= '0;
            r_slot_en   <= '0;
            r_slot_disc <= '0;
            r_known_cnt <= '0;
            r_disc_cnt  <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                for (int s = 0; s < REQ_SLOTS; s++) begin
                    if (s < NUM_SYM_REGS &&
                        i_cfg_idx == REG_REQ_SYMBOL_0 + CFG_IDX_W'(s)) begin
                        r_req_symbol[s] <= i_cfg_wdata[SYMBOL_W-1:0];
                    end
                end
                if (i_cfg_idx == REG_SLOT_ENABLE) begin
                    for (int s = 0; s < REQ_SLOTS; s++) begin
                        r_slot_en[s] <= (s < NUM_SYM_REGS) ? i_cfg_wdata[s] : 1'b0;
                    end
                end
            end
            if (i_cmd.clear_we) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cmd.commit) begin
                r_slot_disc <= n_slot_disc;
                r_known_cnt <= n_known_cnt;
                r_disc_cnt  <= n_disc_cnt;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_item.payload.op;
            r_loc <= i_item.payload.locate[LOCATE_BITS-1:0];
            r_sym <= i_item.payload.stock_symbol;
            r_qs  <= i_item.payload.query_slot;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
            for (int s = 0; s < REQ_SLOTS; s++) begin
                if (new_disc[s]) r_slot_loc[s] <= r_loc;
            end
        end
    end

    `SLD_ASSERT_RST(a_known_only_on_commit, i_clk, i_rst_n, !i_cmd.commit |=> $stable(r_known_cnt), "known count moved without a commit")
    `SLD_ASSERT_RST(a_disc_matches_slots, i_clk, i_rst_n, r_disc_cnt == DISC_W'($countones(r_slot_disc)), "discovered count out of step with slot bits")
endmodule

/* rtl/core/stock_locate_symbol_directory_unit.sv */
// Top level of the stock locate symbol directory: controller plus datapath.
// Depends on sld_pkg, sld_stream_if, sld_ctrl, sld_datapath.
//
// Maps each stock locate to its 8-byte symbol in a 2^LOCATE_BITS-entry
// directory RAM and tracks which requested symbols have shown up. Each item
// is a read-modify-write of the RAM: the idle state reads the locate's
// entry as it accepts the item, then the evaluate state checks the symbol,
// writes a new one into the entry and loads the result register, waiting
// while that register is full and not being drained. The next item is taken
// while a result still waits downstream. After reset a clearing pass writes
// every entry once before the first item is taken; configuration writes are
// taken throughout. Write configuration only while no item is in flight.
module stock_locate_symbol_directory_unit #(
    parameter int LOCATE_BITS = 16,
    parameter int REQ_SLOTS   = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sld_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sld_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    sld_stream_if.sink                     i_item,
    sld_stream_if.source                   o_result
);
    import sld_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status st;

    sld_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    sld_datapath #(
        .LOCATE_BITS (LOCATE_BITS),
        .REQ_SLOTS   (REQ_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_item),
        .o_result    (o_result),
        .i_cmd       (cmd),
        .o_st        (st)
    );
endmodule

/* verif/tb.sv */
// Self-checking bench for stock_locate_symbol_directory_unit: directed and random feed traffic.
// Depends on sld_pkg and sld_stream_if from the RTL tree; the directory is predicted in-bench.
`timescale 1ns / 1ps

module tb;
    import sld_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_AT     = 150;   // replies seen before the long receiver hold-off
    localparam int HOLD_CYCLES = 300;

    localparam logic [SYMBOL_W-1:0] SYM_AAPL = "AAPL    ";
    localparam logic [SYMBOL_W-1:0] SYM_MSFT = "MSFT    ";
    localparam logic [SYMBOL_W-1:0] SYM_TSLA = "TSLA    ";
    localparam logic [SYMBOL_W-1:0] SYM_SPY  = "SPY     ";
    localparam logic [SYMBOL_W-1:0] SYM_ONES = '1;

    logic clk;
    logic rst_n = 1'b0;

    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic  drv_valid = 1'b0;
    t_item drv_item  = '0;
    logic  rcv_ready = 1'b0;

    sld_stream_if #(.T(t_item))   item_if ();
    sld_stream_if #(.T(t_result)) result_if ();

    assign item_if.valid   = drv_valid;
    assign item_if.payload = drv_item;
    assign result_if.ready = rcv_ready;

    stock_locate_symbol_directory_unit u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_wdata(cfg_wdata),
        .i_item     (item_if),
        .o_result   (result_if)
    );

    // predicted directory state
    bit                  dir_known    [0:65535];
    logic [SYMBOL_W-1:0] dir_symbol   [0:65535];
    bit                  dir_selected [0:65535];
    bit                  slot_hit     [4];
    logic [LOCATE_W-1:0] slot_loc     [4];
    logic [KNOWN_W-1:0]  known_total  = '0;
    logic [DISC_W-1:0]   disc_total   = '0;
    logic [SYMBOL_W-1:0] want_sym     [4];
    logic [3:0]          want_en      = '0;

    t_item   feed_msgs_q[$];
    t_result directory_replies_q[$];

    int err_count    = 0;
    int cycle_count  = 0;
    int replies_seen = 0;
    int n_observe    = 0;
    int n_query      = 0;
    int status_hits  [4];

    // sender burst state, receiver stall state
    int burst_left = 0;
    int gap_left   = 0;
    int hold_left  = 0;
    int rcv_mode   = 0;
    int mode_left  = 0;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[stock_locate_symbol_directory_unit] ERROR");
            $finish;
        end
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        err_count++;
        if (err_count <= 40)
            $display("mismatch %0d at cycle %0d, %s: got %h expected %h",
                     err_count, cycle_count, what, got, want);
    endtask

    // Walks the directory for one message or query and returns the reply it should produce.
    function automatic t_result directory_lookup(t_item it);
        t_result             r;
        logic [LOCATE_W-1:0] loc;
        logic [SYMBOL_W-1:0] sym;
        bit                  has_nul;
        bit                  sel;
        loc = it.locate;
        sym = it.stock_symbol;
        r.status = ST_OK;
        if (it.op == OP_OBSERVE) begin
            n_observe++;
            has_nul = 0;
            for (int b = 0; b < SYMBOL_BYTES; b++)
                if (sym[8*b +: 8] == NUL_BYTE) has_nul = 1;
            if (has_nul) begin
                r.status = ST_ZERO_BYTE;
            end else if (sym == SPACE_WORD) begin
                r.status = ST_EMPTY;
            end else if (dir_known[loc]) begin
                if (dir_symbol[loc] != sym) r.status = ST_CONFLICT;
            end else begin
                sel = 0;
                for (int s = 0; s < 4; s++) begin
                    if (want_en[s] && want_sym[s] == sym) begin
                        sel = 1;
                        if (!slot_hit[s]) begin
                            slot_hit[s] = 1;
                            slot_loc[s] = loc;
                            disc_total++;
                        end
                    end
                end
                dir_known[loc]    = 1;
                dir_symbol[loc]   = sym;
                dir_selected[loc] = sel;
                known_total++;
            end
        end else begin
            n_query++;
        end
        status_hits[r.status]++;
        r.known            = dir_known[loc];
        r.selected         = dir_known[loc] && dir_selected[loc];
        r.symbol_out       = dir_known[loc] ? dir_symbol[loc] : '0;
        r.known_count      = known_total;
        r.discovered_count = disc_total;
        r.all_discovered   = (disc_total == DISC_W'($countones(want_en)));
        r.slot_found       = slot_hit[it.query_slot];
        r.slot_locate      = slot_hit[it.query_slot] ? slot_loc[it.query_slot] : '0;
        return r;
    endfunction

    // driver: bursts of transfers with random gaps
    always @(posedge clk) begin
        logic  nxt_valid;
        t_item nxt_item;
        if (!rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            nxt_valid = drv_valid;
            nxt_item  = drv_item;
            if (drv_valid && item_if.ready) begin
                directory_replies_q.insert(directory_replies_q.size(),
                                           directory_lookup(drv_item));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (feed_msgs_q.size() > 0) begin
                    nxt_item  = feed_msgs_q.pop_front();
                    nxt_valid = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end else begin
                        burst_left--;
                    end
                end
            end
            drv_valid <= nxt_valid;
            drv_item  <= nxt_item;
        end
    end

    // monitor: checks each reply transfer and drives the stall pattern
    always @(posedge clk) begin
        t_result got;
        t_result want;
        logic    nxt_ready;
        if (!rst_n) begin
            rcv_ready <= 1'b0;
        end else begin
            if (result_if.valid && rcv_ready) begin
                got = result_if.payload;
                replies_seen++;
                if (directory_replies_q.size() == 0) begin
                    report("reply with none pending, symbol_out", got.symbol_out, '0);
                end else begin
                    want = directory_replies_q.pop_front();
                    if (got.status !== want.status)
                        report("status", got.status, want.status);
                    if (got.known !== want.known)
                        report("known", got.known, want.known);
                    if (got.selected !== want.selected)
                        report("selected", got.selected, want.selected);
                    if (got.symbol_out !== want.symbol_out)
                        report("symbol_out", got.symbol_out, want.symbol_out);
                    if (got.known_count !== want.known_count)
                        report("known_count", got.known_count, want.known_count);
                    if (got.discovered_count !== want.discovered_count)
                        report("discovered_count", got.discovered_count, want.discovered_count);
                    if (got.all_discovered !== want.all_discovered)
                        report("all_discovered", got.all_discovered, want.all_discovered);
                    if (got.slot_found !== want.slot_found)
                        report("slot_found", got.slot_found, want.slot_found);
                    if (got.slot_locate !== want.slot_locate)
                        report("slot_locate", got.slot_locate, want.slot_locate);
                end
                if (replies_seen == HOLD_AT) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                nxt_ready = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rcv_mode  = $urandom_range(0, 3);
                    mode_left = $urandom_range(8, 80);
                end else begin
                    mode_left--;
                end
                case (rcv_mode)
                    0: nxt_ready = 1'b1;
                    1: nxt_ready = ($urandom_range(0, 3) != 0);
                    2: nxt_ready = ($urandom_range(0, 3) == 0);
                    default: nxt_ready = ~rcv_ready;
                endcase
            end
            rcv_ready <= nxt_ready;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        if (idx < NUM_SYM_REGS) want_sym[idx] = data;
        else if (idx == REG_SLOT_ENABLE) want_en = data[3:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_msg(input logic op, input logic [LOCATE_W-1:0] loc,
                            input logic [SYMBOL_W-1:0] sym, input logic [QSLOT_W-1:0] qs);
        t_item it;
        it.op           = op;
        it.locate       = loc;
        it.stock_symbol = sym;
        it.query_slot   = qs;
        feed_msgs_q.insert(feed_msgs_q.size(), it);
    endtask

    // sender pause: nothing queued, nothing offered, every reply back
    task automatic wait_drained();
        do @(negedge clk);
        while (feed_msgs_q.size() != 0 || drv_valid || directory_replies_q.size() != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic run_random(input int count);
        logic [LOCATE_W-1:0] loc;
        logic [SYMBOL_W-1:0] sym;
        int                  k;
        int                  len;
        for (int n = 0; n < count; n++) begin
            // mostly a small locate window so entries get revisited
            k = $urandom_range(0, 9);
            if (k < 6) begin
                loc = LOCATE_W'($urandom_range(0, 31));
            end else if (k < 8) begin
                case ($urandom_range(0, 5))
                    0: loc = 16'h0000;
                    1: loc = 16'hFFFF;
                    2: loc = 16'h8000;
                    3: loc = 16'h7FFF;
                    4: loc = 16'h00FF;
                    default: loc = 16'hFF00;
                endcase
            end else begin
                loc = LOCATE_W'($urandom_range(0, 65535));
            end
            k = $urandom_range(0, 99);
            if (k < 40) begin
                k = $urandom_range(0, 7);
                if (k < 4) begin
                    sym = want_sym[k];
                end else begin
                    case (k)
                        4: sym = SYM_MSFT;
                        5: sym = SYM_AAPL;
                        6: sym = SYM_TSLA;
                        default: sym = SYM_SPY;
                    endcase
                end
            end else if (k < 55) begin
                len = $urandom_range(1, 8);
                for (int b = 0; b < SYMBOL_BYTES; b++)
                    sym[SYMBOL_W-1-8*b -: 8] = (b < len) ? 8'($urandom_range(8'h41, 8'h5A))
                                                         : SPACE_BYTE;
            end else if (k < 75) begin
                for (int b = 0; b < SYMBOL_BYTES; b++)
                    sym[8*b +: 8] = 8'($urandom_range(1, 255));
                // half of these carry an embedded NUL
                if (k < 65) sym[8*$urandom_range(0, 7) +: 8] = NUL_BYTE;
            end else if (k < 80) begin
                sym = SPACE_WORD;
            end else if (k < 90) begin
                sym = {$urandom, $urandom};
            end else begin
                sym = want_sym[$urandom_range(0, 3)] | SPACE_WORD;   // lower-cased request
            end
            if ($urandom_range(0, 9) < 3)
                push_msg(OP_QUERY, loc, {$urandom, $urandom}, QSLOT_W'($urandom_range(0, 3)));
            else
                push_msg(OP_OBSERVE, loc, sym, QSLOT_W'($urandom_range(0, 3)));
        end
    endtask

    initial begin
        status_hits = '{default: 0};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // registers are taken while the directory clears
        write_reg(REG_REQ_SYMBOL_0,        SYM_AAPL);
        write_reg(REG_REQ_SYMBOL_0 + 3'd1, SYM_MSFT);
        write_reg(REG_REQ_SYMBOL_0 + 3'd2, SYM_ONES);
        write_reg(REG_REQ_SYMBOL_0 + 3'd3, SYM_AAPL);   // duplicate of slot 0
        write_reg(REG_SLOT_ENABLE,         '0);

        // nothing enabled, nothing found: all_discovered holds
        push_msg(OP_QUERY, 16'h0000, '0, 2'd0);
        wait_drained();
        write_reg(REG_SLOT_ENABLE, 64'hD);

        push_msg(OP_OBSERVE, 16'h0005, 64'h4142_0020_2020_2020, 2'd0);
        push_msg(OP_OBSERVE, 16'h0005, '0, 2'd1);
        push_msg(OP_OBSERVE, 16'h0005, 64'h2020_2020_2020_2041, 2'd2);
        push_msg(OP_OBSERVE, 16'h0006, SPACE_WORD, 2'd3);
        push_msg(OP_OBSERVE, 16'h0007, "aapl    ", 2'd0);
        push_msg(OP_OBSERVE, 16'hFFFF, SYM_AAPL, 2'd3);
        push_msg(OP_OBSERVE, 16'h0001, SYM_AAPL, 2'd0);
        push_msg(OP_OBSERVE, 16'hFFFF, SYM_AAPL, 2'd1);
        push_msg(OP_OBSERVE, 16'hFFFF, SYM_MSFT, 2'd0);
        push_msg(OP_OBSERVE, 16'h0000, SYM_ONES, 2'd2);
        push_msg(OP_OBSERVE, 16'h0002, SYM_MSFT, 2'd1);  // slot disabled
        push_msg(OP_OBSERVE, 16'hFFFF, 64'h00FF_FFFF_FFFF_FFFF, 2'd3);
        push_msg(OP_OBSERVE, 16'h0000, SPACE_WORD, 2'd2);
        push_msg(OP_OBSERVE, 16'h0005, 64'h4141_4141_4141_4100, 2'd0);
        push_msg(OP_QUERY,   16'hFFFF, {$urandom, $urandom}, 2'd0);
        push_msg(OP_QUERY,   16'h0001, {$urandom, $urandom}, 2'd1);
        push_msg(OP_QUERY,   16'h0007, {$urandom, $urandom}, 2'd2);
        push_msg(OP_QUERY,   16'h3039, {$urandom, $urandom}, 2'd3);
        push_msg(OP_QUERY,   16'hAAAA, SYM_ONES, 2'd2);
        push_msg(OP_OBSERVE, 16'h8000, "ZZZZZZZZ", 2'd1);
        push_msg(OP_OBSERVE, 16'h8000, "ZZZZZZZY", 2'd3);
        wait_drained();

        // slot 1 comes in; slot 0 set to a word that can never match
        write_reg(REG_REQ_SYMBOL_0, '0);
        write_reg(REG_SLOT_ENABLE,  64'h3);
        run_random(300);
        wait_drained();

        write_reg(REG_SLOT_ENABLE, '0);
        run_random(250);
        wait_drained();

        write_reg(REG_REQ_SYMBOL_0,        SYM_TSLA);
        write_reg(REG_REQ_SYMBOL_0 + 3'd1, SYM_ONES);
        write_reg(REG_REQ_SYMBOL_0 + 3'd3, SYM_TSLA);
        write_reg(REG_SLOT_ENABLE,         64'hF);
        run_random(350);
        wait_drained();
        repeat (10) @(posedge clk);

        if (directory_replies_q.size() != 0)
            report("replies still pending at end", directory_replies_q.size(), 0);

        $display("covered %0d observes and %0d queries; ok/nul/empty/conflict = %0d/%0d/%0d/%0d",
                 n_observe, n_query, status_hits[ST_OK], status_hits[ST_ZERO_BYTE],
                 status_hits[ST_EMPTY], status_hits[ST_CONFLICT]);
        $display("locates stored %0d, slots discovered %0d, mismatches %0d",
                 known_total, disc_total, err_count);
        if (err_count == 0) begin
            $display("[stock_locate_symbol_directory_unit] OK");
        end else begin
            $display("[stock_locate_symbol_directory_unit] ERROR");
        end
        $finish;
    end

endmodule
